// ----- sv/avc_pkg.sv -----
// ----------------------------------------------------------------------------
// avc_pkg: shared types and constants of the accelerating virtual cursor
// Field widths, register codes, reset values, sequencer states and the
// divider status bundle, and a direction folding helper.
// ----------------------------------------------------------------------------
package avc_pkg;

  localparam int COORD_BITS_DEF    = 10;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int DIM_W      = 11;
  localparam int SPEED_W    = 6;
  localparam int ACCEL_W    = 8;
  localparam int HOLD_W     = 8;
  localparam int DIR_W      = 2;
  localparam int VEL_W      = 12;
  // |hold * (max - base)| is at most 255 * 63 < 2^14
  localparam int DIV_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TICKS   = 3'd4;

  localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RST  = 11'd320;
  localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RST = 11'd240;
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST    = 6'd1;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST     = 6'd8;
  localparam logic [ACCEL_W-1:0] ACCEL_TICKS_RST   = 8'd10;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Fold the unused code minus two onto minus one
  function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [DIR_W-1:0] d);
    return (d == 2'sb10) ? 2'sb11 : d;
  endfunction

endpackage

// ----- sv/accelerating_virtual_cursor.sv -----
// ----------------------------------------------------------------------------
// accelerating_virtual_cursor: cursor motion from direction pad and stick
// Moves a screen cursor once per tick with accelerating digital speed and
// sub-pixel analog motion, clamped to the screen.
// ----------------------------------------------------------------------------
// One input item (a tick) yields one result item. The block takes no new
// item until the last is through: it accepts the item, runs the shared
// restoring divider that computes the acceleration ramp step, sees the
// divider finish, then forms, clamps and registers the position.
// in_tready is low from acceptance until the result is written to the
// output register; a result waiting there does not hold off the next item
// unless the following result is ready before it is taken. Configuration
// writes are taken in any cycle and must only be made while the block is
// idle. No clearing pass follows reset.
module accelerating_virtual_cursor #(
  parameter int  COORD_BITS    = avc_pkg::COORD_BITS_DEF,
  parameter int  FRACTION_BITS = avc_pkg::FRACTION_BITS_DEF,
  localparam int IN_W  = ((4 + 2 * avc_pkg::VEL_W + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // dpad_x, dpad_y, analog_x, analog_y, external_x, external_y, zero pad
  input  logic [IN_W-1:0]                 in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // cursor_x, cursor_y, zero pad
  output logic [OUT_W-1:0]                out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [avc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [avc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int STW   = (COORD_BITS > avc_pkg::DIM_W - 1) ? COORD_BITS : avc_pkg::DIM_W - 1;
  localparam int RMW   = FRACTION_BITS + 1;
  localparam int DX_L  = 0;
  localparam int DY_L  = avc_pkg::DIR_W;
  localparam int AX_L  = 2 * avc_pkg::DIR_W;
  localparam int AY_L  = AX_L + avc_pkg::VEL_W;
  localparam int EX_L  = AY_L + avc_pkg::VEL_W;
  localparam int EY_L  = EX_L + COORD_BITS;
  localparam int SPW   = avc_pkg::DIV_W + 2;

  // configuration
  logic [avc_pkg::DIM_W-1:0]   screen_w_r;
  logic [avc_pkg::DIM_W-1:0]   screen_h_r;
  logic [avc_pkg::SPEED_W-1:0] base_r;
  logic [avc_pkg::SPEED_W-1:0] max_r;
  logic [avc_pkg::ACCEL_W-1:0] accel_r;

  // state
  avc_pkg::state_t             state_r, state_nxt;
  logic                        started_r;
  logic [avc_pkg::HOLD_W-1:0]  hold_r;
  logic signed [RMW-1:0]       rem_x_r, rem_y_r;

  // latched item
  logic signed [avc_pkg::DIR_W-1:0] dx_r, dy_r;
  logic signed [avc_pkg::VEL_W-1:0] ax_r, ay_r;
  logic [STW-1:0]                   sx_r, sy_r;
  logic                             still_r;
  logic                             neg_r;

  logic                        out_valid_r;
  logic [OUT_W-1:0]            out_data_r;

  // decode
  logic                             in_accept;
  logic                             fin_go;
  logic                             div_start;
  logic signed [avc_pkg::DIR_W-1:0] dx, dy;
  logic signed [avc_pkg::VEL_W-1:0] ax, ay;
  logic [COORD_BITS-1:0]            ex, ey;
  logic [STW-1:0]                   sx, sy;
  logic                             still, digital;
  logic [avc_pkg::ACCEL_W-1:0]      acc;
  logic [avc_pkg::HOLD_W-1:0]       h;
  logic [avc_pkg::HOLD_W-1:0]       hold_nxt;
  logic                             diff_neg;
  logic [avc_pkg::SPEED_W-1:0]      diff_mag;
  logic [avc_pkg::DIV_W-1:0]        prod;

  logic [avc_pkg::DIV_W-1:0]        quotient;
  avc_pkg::div_stat_t               div_stat;
  logic signed [SPW-1:0]            sq;
  logic signed [SPW-1:0]            spd_full;
  logic [avc_pkg::SPEED_W-1:0]      spd;
  logic [COORD_BITS-1:0]            pos_x, pos_y;
  logic signed [RMW-1:0]            rem_x_nxt, rem_y_nxt;

  assign cfg_ready  = 1'b1;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    dx = avc_pkg::sat_dir($signed(in_tdata[DX_L +: avc_pkg::DIR_W]));
    dy = avc_pkg::sat_dir($signed(in_tdata[DY_L +: avc_pkg::DIR_W]));
    ax = $signed(in_tdata[AX_L +: avc_pkg::VEL_W]);
    ay = $signed(in_tdata[AY_L +: avc_pkg::VEL_W]);
    ex = in_tdata[EX_L +: COORD_BITS];
    ey = in_tdata[EY_L +: COORD_BITS];

    // first tick starts from the centre on an axis whose position is zero
    sx = (!started_r && ex == '0) ? STW'(screen_w_r >> 1) : STW'(ex);
    sy = (!started_r && ey == '0) ? STW'(screen_h_r >> 1) : STW'(ey);

    digital = (dx != '0) || (dy != '0);
    still   = !digital && (ax == '0) && (ay == '0);

    acc      = (accel_r == '0) ? avc_pkg::ACCEL_W'(1) : accel_r;
    h        = (hold_r > acc) ? acc : hold_r;
    if (!digital) begin
      hold_nxt = '0;
    end else if (hold_r >= acc) begin
      hold_nxt = acc;
    end else begin
      hold_nxt = hold_r + avc_pkg::HOLD_W'(1);
    end
    diff_neg = (max_r < base_r);
    diff_mag = diff_neg ? base_r - max_r : max_r - base_r;
    prod     = avc_pkg::DIV_W'(h) * avc_pkg::DIV_W'(diff_mag);

    // speed = base + signed quotient, capped at max
    sq       = neg_r ? -$signed(SPW'(quotient)) : $signed(SPW'(quotient));
    spd_full = $signed(SPW'(base_r)) + sq;
    spd      = (spd_full > $signed(SPW'(max_r))) ? max_r : spd_full[avc_pkg::SPEED_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    fin_go    = 1'b0;
    case (state_r)
      avc_pkg::S_IDLE: begin
        // stay closed while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          div_start = 1'b1;
          state_nxt = avc_pkg::S_DIV;
        end
      end
      avc_pkg::S_DIV: begin
        if (div_stat.done && !div_stat.busy) begin
          state_nxt = avc_pkg::S_FIN;
        end
      end
      avc_pkg::S_FIN: begin
        // hold while the previous result is still waiting
        if (!out_valid_r || out_tready) begin
          fin_go    = 1'b1;
          state_nxt = avc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = avc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= avc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= avc_pkg::SCREEN_WIDTH_RST;
      screen_h_r <= avc_pkg::SCREEN_HEIGHT_RST;
      base_r     <= avc_pkg::BASE_SPEED_RST;
      max_r      <= avc_pkg::MAX_SPEED_RST;
      accel_r    <= avc_pkg::ACCEL_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        avc_pkg::CFG_SCREEN_WIDTH:  screen_w_r <= cfg_data;
        avc_pkg::CFG_SCREEN_HEIGHT: screen_h_r <= cfg_data;
        avc_pkg::CFG_BASE_SPEED:    base_r     <= cfg_data[avc_pkg::SPEED_W-1:0];
        avc_pkg::CFG_MAX_SPEED:     max_r      <= cfg_data[avc_pkg::SPEED_W-1:0];
        avc_pkg::CFG_ACCEL_TICKS:   accel_r    <= cfg_data[avc_pkg::ACCEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      hold_r      <= '0;
      rem_x_r     <= '0;
      rem_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        started_r <= 1'b1;
        hold_r    <= hold_nxt;
      end
      if (fin_go) begin
        rem_x_r     <= still_r ? '0 : rem_x_nxt;
        rem_y_r     <= still_r ? '0 : rem_y_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      dx_r    <= dx;
      dy_r    <= dy;
      ax_r    <= ax;
      ay_r    <= ay;
      sx_r    <= sx;
      sy_r    <= sy;
      still_r <= still;
      neg_r   <= diff_neg;
    end
    if (fin_go) begin
      out_data_r <= OUT_W'({pos_y, pos_x});
    end
  end

  avc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .divisor  (acc),
    .quotient (quotient),
    .stat     (div_stat)
  );

  avc_axis #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_axis_x (
    .still   (still_r),
    .start   (sx_r),
    .dir     (dx_r),
    .spd     (spd),
    .vel     (ax_r),
    .rem     (rem_x_r),
    .size    (screen_w_r),
    .pos     (pos_x),
    .rem_nxt (rem_x_nxt)
  );

  avc_axis #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_axis_y (
    .still   (still_r),
    .start   (sy_r),
    .dir     (dy_r),
    .spd     (spd),
    .vel     (ay_r),
    .rem     (rem_y_r),
    .size    (screen_h_r),
    .pos     (pos_y),
    .rem_nxt (rem_y_nxt)
  );

endmodule

// ----- sv/avc_divider.sv -----
// ----------------------------------------------------------------------------
// avc_divider: restoring divider for the acceleration ramp
// One quotient bit per cycle; divides an unsigned product by the ramp length.
// ----------------------------------------------------------------------------
module avc_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [avc_pkg::DIV_W-1:0]   dividend,
  input  logic [avc_pkg::ACCEL_W-1:0] divisor,
  output logic [avc_pkg::DIV_W-1:0]   quotient,
  output avc_pkg::div_stat_t          stat
);

  localparam int CNT_W = $clog2(avc_pkg::DIV_W);

  logic [avc_pkg::DIV_W-1:0]   q_r;
  logic [avc_pkg::ACCEL_W-1:0] rem_r;
  logic [avc_pkg::ACCEL_W-1:0] div_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [avc_pkg::ACCEL_W:0]   shifted;
  logic [avc_pkg::ACCEL_W-1:0] diff;
  logic                        qbit;

  always_comb begin
    shifted = {rem_r, q_r[avc_pkg::DIV_W-1]};
    // only used when shifted >= divisor, so the difference fits ACCEL_W bits
    diff    = shifted[avc_pkg::ACCEL_W-1:0] - div_r;
    qbit    = (shifted >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(avc_pkg::DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so it fits ACCEL_W bits
      q_r   <= {q_r[avc_pkg::DIV_W-2:0], qbit};
      rem_r <= qbit ? diff : shifted[avc_pkg::ACCEL_W-1:0];
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- sv/avc_axis.sv -----
// ----------------------------------------------------------------------------
// avc_axis: per-axis position update
// Adds the digital step and the whole pixels of the analog remainder to the
// start position, then clamps to the screen; with no motion the start passes through.
// ----------------------------------------------------------------------------
module avc_axis #(
  parameter int  COORD_BITS    = avc_pkg::COORD_BITS_DEF,
  parameter int  FRACTION_BITS = avc_pkg::FRACTION_BITS_DEF,
  localparam int STW = (COORD_BITS > avc_pkg::DIM_W - 1) ? COORD_BITS : avc_pkg::DIM_W - 1,
  localparam int RMW = FRACTION_BITS + 1
) (
  input  logic                               still,
  input  logic [STW-1:0]                     start,
  input  logic signed [avc_pkg::DIR_W-1:0]   dir,
  input  logic [avc_pkg::SPEED_W-1:0]        spd,
  input  logic signed [avc_pkg::VEL_W-1:0]   vel,
  input  logic signed [RMW-1:0]              rem,
  input  logic [avc_pkg::DIM_W-1:0]          size,
  output logic [COORD_BITS-1:0]              pos,
  output logic signed [RMW-1:0]              rem_nxt
);

  localparam int RW = ((avc_pkg::VEL_W > RMW) ? avc_pkg::VEL_W : RMW) + 1;
  localparam int SW = ((COORD_BITS + 3) > RW) ? COORD_BITS + 3 : RW;

  logic signed [RW-1:0]          r;
  logic signed [RW-1:0]          r_bias;
  logic signed [RW-1:0]          whole;
  logic signed [RW-1:0]          rem_d;
  logic [RW-1:0]                 frac_mask;
  logic signed [SW-1:0]          step;
  logic signed [SW-1:0]          sum;
  logic [avc_pkg::DIM_W-1:0]     size_one;
  logic [avc_pkg::DIM_W-1:0]     lim_raw;
  logic signed [SW-1:0]          lim_s;
  logic signed [SW-1:0]          cmax;
  logic signed [SW-1:0]          lim;
  logic signed [SW-1:0]          clamped;

  always_comb begin
    frac_mask = {{(RW - FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}};
    r         = RW'(rem) + RW'(vel);
    // bias negative sums so the shift truncates toward zero
    r_bias    = r[RW-1] ? r + $signed(frac_mask) : r;
    whole     = r_bias >>> FRACTION_BITS;
    rem_d     = r - (whole <<< FRACTION_BITS);
    rem_nxt   = $signed(rem_d[RMW-1:0]);

    if (dir == '0) begin
      step = '0;
    end else if (dir[avc_pkg::DIR_W-1]) begin
      step = -$signed(SW'(spd));
    end else begin
      step = $signed(SW'(spd));
    end
    sum = $signed(SW'(start)) + step + SW'(whole);

    size_one = (size == '0) ? avc_pkg::DIM_W'(1) : size;
    lim_raw  = size_one - avc_pkg::DIM_W'(1);
    lim_s    = $signed(SW'(lim_raw));
    cmax     = $signed(SW'({COORD_BITS{1'b1}}));
    lim      = (lim_s > cmax) ? cmax : lim_s;

    if (sum < 0) begin
      clamped = '0;
    end else if (sum > lim) begin
      clamped = lim;
    end else begin
      clamped = sum;
    end

    pos = still ? start[COORD_BITS-1:0] : clamped[COORD_BITS-1:0];
  end

endmodule

// ----- sv/avc_checker.sv -----
// ----------------------------------------------------------------------------
// avc_checker: port-level checks for the accelerating virtual cursor
// Watches the stream handshakes and the busy window after an item.
// ----------------------------------------------------------------------------
module avc_checker #(
  parameter int  COORD_BITS = avc_pkg::COORD_BITS_DEF,
  localparam int OUT_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // an accepted item keeps the input closed as the divider run begins
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input reopened too early after an item");

  // a new result only follows a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without work");

endmodule

bind accelerating_virtual_cursor avc_checker #(
  .COORD_BITS (COORD_BITS)
) u_avc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- dv/accelerating_virtual_cursor_tb.sv -----
// ----------------------------------------------------------------------------
// accelerating_virtual_cursor_tb: self-checking bench for the virtual cursor
// Drives ticks on the input stream and predicts every cursor position.
// Covers first-tick centering, the digital speed ramp, sub-pixel stick
// motion, screen clamping and a long receiver hold-off. Then runs random
// phases under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module accelerating_virtual_cursor_tb;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int FRAC_BITS    = avc_pkg::FRACTION_BITS_DEF;
  localparam int FRAC_ONE     = 1 << avc_pkg::FRACTION_BITS_DEF;
  localparam int COORD_LIMIT  = (1 << avc_pkg::COORD_BITS_DEF) - 1;

  // Packed MSB first so that the struct is the tdata layout itself
  typedef struct packed {
    logic [9:0]  ey;
    logic [9:0]  ex;
    logic [11:0] ay;
    logic [11:0] ax;
    logic [1:0]  dy;
    logic [1:0]  dx;
  } tick_t;

  typedef struct packed {
    logic [9:0] y;
    logic [9:0] x;
  } pos_t;

  typedef enum int {
    RUN_STILL,
    RUN_DPAD,
    RUN_STICK,
    RUN_BOTH,
    RUN_NOISE
  } run_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // dpad_x, dpad_y, analog_x, analog_y, external_x, external_y
  logic [$bits(tick_t)-1:0] in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // cursor_x, cursor_y, zero pad
  logic [23:0]           out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [avc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [avc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  accelerating_virtual_cursor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cursor model state and register copies
  int   scr_w = int'(avc_pkg::SCREEN_WIDTH_RST);
  int   scr_h = int'(avc_pkg::SCREEN_HEIGHT_RST);
  int   base_spd = int'(avc_pkg::BASE_SPEED_RST);
  int   max_spd = int'(avc_pkg::MAX_SPEED_RST);
  int   ramp_ticks = int'(avc_pkg::ACCEL_TICKS_RST);
  bit   started = 1'b0;
  int   hold_ticks = 0;
  int   frac_x = 0;
  int   frac_y = 0;

  pos_t cursor_q[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   sender_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   holdoff_left = 0;

  // Random run state; the shared cursor follows the model's predicted positions
  run_kind_t  run_kind = RUN_STILL;
  int         run_left = 0;
  logic [1:0]  run_dx, run_dy;
  logic [11:0] run_ax, run_ay;
  logic [9:0]  shared_x = '0;
  logic [9:0]  shared_y = '0;

  function automatic int trunc_px(int r);
    return (r >= 0) ? (r >>> FRAC_BITS) : -((-r) >>> FRAC_BITS);
  endfunction

  function automatic int clamp_coord(int v, int size);
    int lim;
    lim = ((size == 0) ? 1 : size) - 1;
    if (lim > COORD_LIMIT) lim = COORD_LIMIT;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return v;
  endfunction

  function automatic pos_t advance_cursor(tick_t t);
    int   dx, dy, ax, ay, x, y, ramp, h, spd, rx, ry, wx, wy;
    pos_t p;
    dx = int'($signed(t.dx));
    dy = int'($signed(t.dy));
    if (dx < -1) dx = -1;
    if (dy < -1) dy = -1;
    ax = int'($signed(t.ax));
    ay = int'($signed(t.ay));
    if (!started) begin
      x = (t.ex != 0) ? int'(t.ex) : (scr_w >> 1);
      y = (t.ey != 0) ? int'(t.ey) : (scr_h >> 1);
      started = 1'b1;
    end else begin
      x = int'(t.ex);
      y = int'(t.ey);
    end
    if (dx == 0 && dy == 0 && ax == 0 && ay == 0) begin
      // no motion: start position passes through unclamped
      hold_ticks = 0;
      frac_x = 0;
      frac_y = 0;
    end else begin
      ramp = (ramp_ticks == 0) ? 1 : ramp_ticks;
      if (dx != 0 || dy != 0) begin
        h = (hold_ticks > ramp) ? ramp : hold_ticks;
        spd = base_spd + (h * (max_spd - base_spd)) / ramp;
        if (spd > max_spd) spd = max_spd;
        x += dx * spd;
        y += dy * spd;
        hold_ticks = (hold_ticks >= ramp) ? ramp : hold_ticks + 1;
      end else begin
        hold_ticks = 0;
      end
      rx = frac_x + ax;
      ry = frac_y + ay;
      wx = trunc_px(rx);
      wy = trunc_px(ry);
      frac_x = rx - wx * FRAC_ONE;
      frac_y = ry - wy * FRAC_ONE;
      x = clamp_coord(x + wx, scr_w);
      y = clamp_coord(y + wy, scr_h);
    end
    p.x = x[9:0];
    p.y = y[9:0];
    return p;
  endfunction

  function automatic tick_t make_tick(int dx, int dy, int ax, int ay, int ex, int ey);
    tick_t t;
    t.dx = dx[1:0];
    t.dy = dy[1:0];
    t.ax = ax[11:0];
    t.ay = ay[11:0];
    t.ex = ex[9:0];
    t.ey = ey[9:0];
    return t;
  endfunction

  function automatic logic [11:0] random_velocity();
    int v;
    if ($urandom_range(3) == 0) v = int'($urandom_range(4095)) - 2048;
    else v = int'($urandom_range(800)) - 400;
    return v[11:0];
  endfunction

  // Result checker
  always @(posedge clk) begin
    pos_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[19:0];
      if (cursor_q.size() == 0) begin
        $error("cursor item with nothing expected: x %0d y %0d", got.x, got.y);
        mismatch_count++;
      end else begin
        want = cursor_q.pop_front();
        if (got.x !== want.x) begin
          $error("cursor_x mismatch: expected %0d, got %0d", want.x, got.x);
          mismatch_count++;
        end
        if (got.y !== want.y) begin
          $error("cursor_y mismatch: expected %0d, got %0d", want.y, got.y);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a counted hold-off when one is requested
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      out_tready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL accelerating_virtual_cursor");
      $finish;
    end
  end

  task automatic send_tick(input tick_t t);
    pos_t p;
    in_tvalid <= 1'b1;
    in_tdata <= t;
    do @(posedge clk); while (!in_tready);
    p = advance_cursor(t);
    cursor_q.push_back(p);
    shared_x = p.x;
    shared_y = p.y;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (cursor_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [avc_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[avc_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      avc_pkg::CFG_SCREEN_WIDTH:  scr_w = val & 'h7FF;
      avc_pkg::CFG_SCREEN_HEIGHT: scr_h = val & 'h7FF;
      avc_pkg::CFG_BASE_SPEED:    base_spd = val & 'h3F;
      avc_pkg::CFG_MAX_SPEED:     max_spd = val & 'h3F;
      avc_pkg::CFG_ACCEL_TICKS:   ramp_ticks = val & 'hFF;
      default: ;
    endcase
  endtask

  task automatic apply_config(input int w, input int h, input int b, input int m,
                              input int a);
    drain_results();
    cfg_write(avc_pkg::CFG_SCREEN_WIDTH, w);
    cfg_write(avc_pkg::CFG_SCREEN_HEIGHT, h);
    cfg_write(avc_pkg::CFG_BASE_SPEED, b);
    cfg_write(avc_pkg::CFG_MAX_SPEED, m);
    cfg_write(avc_pkg::CFG_ACCEL_TICKS, a);
    cfg_valid <= 1'b0;
  endtask

  task automatic next_random_tick(output tick_t t);
    int r;
    if (run_left == 0) begin
      r = $urandom_range(9);
      run_kind = (r == 0) ? RUN_STILL : (r < 5) ? RUN_DPAD :
                 (r < 7) ? RUN_STICK : (r < 9) ? RUN_BOTH : RUN_NOISE;
      run_left = (run_kind == RUN_STILL) ? $urandom_range(1, 3) : $urandom_range(1, 24);
      run_dx = 2'($urandom_range(3));
      run_dy = 2'($urandom_range(3));
      if (run_dx == 2'b00 && run_dy == 2'b00) run_dx = 2'b01;
      run_ax = random_velocity();
      run_ay = ($urandom_range(3) == 0) ? 12'd0 : random_velocity();
    end
    run_left--;
    t = '0;
    case (run_kind)
      RUN_DPAD: begin
        t.dx = run_dx;
        t.dy = run_dy;
      end
      RUN_STICK: begin
        t.ax = run_ax;
        t.ay = run_ay;
      end
      RUN_BOTH: begin
        t.dx = run_dx;
        t.dy = run_dy;
        t.ax = run_ax;
        t.ay = run_ay;
      end
      RUN_NOISE: begin
        t.dx = 2'($urandom_range(3));
        t.dy = 2'($urandom_range(3));
        t.ax = 12'($urandom_range(4095));
        t.ay = 12'($urandom_range(4095));
      end
      default: ;
    endcase
    // mostly follow the shared cursor; now and then a touch moves it
    if ($urandom_range(7) == 0) begin
      t.ex = 10'($urandom_range(1023));
      t.ey = 10'($urandom_range(1023));
    end else begin
      t.ex = shared_x;
      t.ey = shared_y;
    end
  endtask

  task automatic test_first_tick();
    // centre on x only, then a zero external x is taken as is
    send_tick(make_tick(0, 0, 0, 0, 0, 77));
    send_tick(make_tick(0, 0, 0, 0, 0, 1023));
  endtask

  task automatic test_digital_ramp();
    int i;
    apply_config(320, 240, 2, 20, 3);
    for (i = 0; i < 5; i++) send_tick(make_tick(1, -2, 0, 0, 100, 100));
    // hold count now sits above the lowered ramp length
    apply_config(320, 240, 2, 20, 1);
    send_tick(make_tick(-1, 1, 0, 0, 100, 100));
    apply_config(320, 240, 2, 20, 0);
    send_tick(make_tick(1, 0, 0, 0, 100, 100));
    send_tick(make_tick(0, 1, 0, 0, 100, 100));
    // cap below base
    apply_config(320, 240, 63, 0, 4);
    send_tick(make_tick(-1, 1, 0, 0, 200, 100));
  endtask

  task automatic test_stick_subpixel();
    apply_config(320, 240, 1, 8, 10);
    send_tick(make_tick(0, 0, 2047, -2048, 150, 120));
    send_tick(make_tick(0, 0, -1, 1, 150, 120));
    send_tick(make_tick(0, 0, 129, -129, 150, 120));
    send_tick(make_tick(0, 0, 0, 0, 150, 120));
    send_tick(make_tick(1, 1, -300, 255, 150, 120));
  endtask

  task automatic test_screen_clamp();
    apply_config(0, 2047, 63, 63, 255);
    send_tick(make_tick(1, 1, 2047, 2047, 1023, 1023));
    send_tick(make_tick(-1, -1, -2048, -2048, 0, 0));
    apply_config(2047, 1, 63, 63, 255);
    send_tick(make_tick(1, 1, 0, 0, 1000, 1000));
  endtask

  task automatic test_holdoff_fill();
    tick_t t;
    int    i;
    apply_config(320, 240, 1, 8, 10);
    sender_idle_pct = 0;
    rx_stall_pct <= 0;
    holdoff_left <= 300;
    for (i = 0; i < 20; i++) begin
      next_random_tick(t);
      send_tick(t);
    end
    // wait for every result before going on
    drain_results();
    for (i = 0; i < 2; i++) begin
      next_random_tick(t);
      send_tick(t);
    end
  endtask

  task automatic test_random_phases();
    tick_t t;
    int    ph, i;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_config(2047, 2047, 63, 63, 255);
        1: apply_config(0, 0, 0, 0, 0);
        2: apply_config(320, 240, 1, 8, 10);
        3: apply_config(1024, 1, 5, 2, 1);
        default: apply_config($urandom_range(1) ? $urandom_range(1, 1024) : $urandom_range(2047),
                              $urandom_range(1) ? $urandom_range(1, 1024) : $urandom_range(2047),
                              $urandom_range(63), $urandom_range(63),
                              $urandom_range(3) ? $urandom_range(1, 16) : $urandom_range(255));
      endcase
      case (ph % 4)
        0: begin sender_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin sender_idle_pct = 82; rx_stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  rx_stall_pct <= 82; end
        default: begin sender_idle_pct = 23; rx_stall_pct <= 23; end
      endcase
      for (i = 0; i < 160; i++) begin
        next_random_tick(t);
        send_tick(t);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_first_tick();
    test_digital_ramp();
    test_stick_subpixel();
    test_screen_clamp();
    test_holdoff_fill();
    test_random_phases();
    drain_results();
    if (mismatch_count == 0) begin
      $display("PASS accelerating_virtual_cursor");
    end else begin
      $display("FAIL accelerating_virtual_cursor");
    end
    $finish;
  end

endmodule
